>>> hw/rtl/group_reverse_stream_macros.svh
// Assertion macros for the group reversal RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GROUP_REVERSE_STREAM_MACROS_SVH
`define GROUP_REVERSE_STREAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/grs_pkg.sv
// Shared constants and types for the group reversal stream block.
// No dependencies; used by grs_ctrl, grs_drain and group_reverse_stream.
package grs_pkg;

	localparam int MAX_GROUP_DEF  = 32;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int CFG_W          = 6;
	localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 6'd1;

	// One buffer read issued by the controller toward the output stage.
	typedef struct packed {
		logic issue;
		logic group_done;
		logic list_done;
	} grs_rd_t;

endpackage

>>> hw/rtl/grs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module grs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/grs_ctrl.sv
// Fill and drain sequencing: group size register, fill count, buffer addresses.
// Depends on grs_pkg.
module grs_ctrl #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [grs_pkg::CFG_W-1:0]       group_size,
	input  logic                            in_valid,
	input  logic                            list_end,
	output logic                            in_stall,
	output logic                            wr_en,
	output logic [$clog2(MAX_GROUP)-1:0]    wr_addr,
	input  logic                            can_issue,
	output grs_pkg::grs_rd_t                rd,
	output logic [$clog2(MAX_GROUP)-1:0]    rd_addr,
	output logic [$clog2(MAX_GROUP+1)-1:0]  fill
);

	localparam int AW = $clog2(MAX_GROUP);
	localparam int FW = $clog2(MAX_GROUP + 1);
	localparam int KW = (FW > grs_pkg::CFG_W) ? FW : grs_pkg::CFG_W;

	logic [grs_pkg::CFG_W-1:0] group_size_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] rem_q;
	logic          last_q;

	logic [KW-1:0] gs_ext;
	logic [KW-1:0] max_k;
	logic [KW-1:0] k_eff;
	logic [FW-1:0] cnt;
	logic          full;
	logic          accept;
	logic          release_grp;
	logic          issue;

	assign gs_ext = KW'(group_size_q);
	assign max_k  = KW'(MAX_GROUP);
	// A size of zero acts as one; sizes above the buffer depth saturate.
	assign k_eff  = (gs_ext == '0) ? KW'(1) : ((gs_ext > max_k) ? max_k : gs_ext);

	assign in_stall    = (rem_q != '0);
	assign accept      = in_valid && !in_stall;
	assign full        = (fill_q == FW'(MAX_GROUP));
	assign cnt         = full ? fill_q : fill_q + FW'(1);
	assign release_grp = (KW'(cnt) >= k_eff) || list_end;

	assign wr_en   = accept && !full;
	assign wr_addr = fill_q[AW-1:0];

	// The newest item sits at the highest address, so reads count down.
	assign issue         = (rem_q != '0) && can_issue;
	assign rd.issue      = issue;
	assign rd.group_done = (rem_q == FW'(1));
	assign rd.list_done  = (rem_q == FW'(1)) && last_q;
	assign rd_addr       = AW'(rem_q - FW'(1));
	assign fill          = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= grs_pkg::GROUP_SIZE_RESET;
			fill_q       <= '0;
			rem_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				group_size_q <= group_size;
			end
			if (accept) begin
				if (release_grp) begin
					fill_q <= '0;
					rem_q  <= cnt;
					last_q <= list_end;
				end else begin
					fill_q <= cnt;
				end
			end else if (issue) begin
				rem_q <= rem_q - FW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/grs_drain.sv
// Output stage: tracks the RAM read in flight and holds the result beat.
// Depends on grs_pkg.
module grs_drain #(
	parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  grs_pkg::grs_rd_t              rd,
	input  logic [DATA_WIDTH-1:0]         rdata,
	output logic                          can_issue,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [grs_pkg::VALUE_W-1:0]   out_value,
	output logic                          group_done,
	output logic                          list_done
);

	localparam int EW = (DATA_WIDTH > grs_pkg::VALUE_W) ? DATA_WIDTH : grs_pkg::VALUE_W;

	logic          pend_s1;
	logic          gd_s1;
	logic          ld_s1;
	logic          move;
	logic [EW-1:0] rdata_ext;

	// RAM output holds while no new read is issued, so it doubles as a stage.
	assign move      = pend_s1 && (!out_valid || !out_stall);
	assign can_issue = !pend_s1 || move;
	assign rdata_ext = EW'(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rd.issue) begin
				pend_s1 <= 1'b1;
			end else if (move) begin
				pend_s1 <= 1'b0;
			end
			if (move) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.issue) begin
			gd_s1 <= rd.group_done;
			ld_s1 <= rd.list_done;
		end
		if (move) begin
			out_value  <= rdata_ext[grs_pkg::VALUE_W-1:0];
			group_done <= gd_s1;
			list_done  <= ld_s1;
		end
	end

endmodule

>>> hw/rtl/group_reverse_stream.sv
// After the beat that closes a group, its first result passes through the drain
// counter, the RAM read register and the output register. Throughput: items enter one per
// cycle while a group fills; a closed group then holds the input stalled, longer under
// output stall, while the buffer drains. Results leave at one per cycle unless the output
// is stalled. Reset clears the fill count, the drain counter and the output stage and
// sets the group size to 1; buffer contents are not cleared and need no clearing pass.
`include "group_reverse_stream_macros.svh"

module group_reverse_stream #(
	parameter int MAX_GROUP  = grs_pkg::MAX_GROUP_DEF,
	parameter int DATA_WIDTH = grs_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [grs_pkg::CFG_W-1:0]          group_size,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [grs_pkg::VALUE_W-1:0] item_value,
	input  logic                               list_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [grs_pkg::VALUE_W-1:0] out_value,
	output logic                               group_done,
	output logic                               list_done
);

	localparam int AW = $clog2(MAX_GROUP);
	localparam int FW = $clog2(MAX_GROUP + 1);
	localparam int EW = (DATA_WIDTH > grs_pkg::VALUE_W) ? DATA_WIDTH : grs_pkg::VALUE_W;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  can_issue;
	logic [FW-1:0]         fill;
	logic [grs_pkg::VALUE_W-1:0] value_u;
	grs_pkg::grs_rd_t      rd;

	assign cfg_ready = 1'b1;
	assign wdata     = DATA_WIDTH'(EW'($unsigned(item_value)));

	grs_ctrl #(
		.MAX_GROUP(MAX_GROUP)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.group_size(group_size),
		.in_valid  (in_valid),
		.list_end  (list_end),
		.in_stall  (in_stall),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.can_issue (can_issue),
		.rd        (rd),
		.rd_addr   (rd_addr),
		.fill      (fill)
	);

	grs_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(MAX_GROUP)
	) u_buf (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wdata),
		.re   (rd.issue),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	grs_drain #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.rdata     (rdata),
		.can_issue (can_issue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (value_u),
		.group_done(group_done),
		.list_done (list_done)
	);

	assign out_value = $signed(value_u);

	`GRS_ASSERT_NOW(a_list_done_ends_group, clk, arst_n, out_valid && list_done, group_done, "list_done without group_done")
	`GRS_ASSERT_NEXT(a_list_end_releases, clk, arst_n, in_valid && !in_stall && list_end, in_stall && fill == '0, "list end beat did not release the group")
	`GRS_ASSERT_NOW(a_fill_bounded, clk, arst_n, 1'b1, fill < FW'(MAX_GROUP), "fill count reached buffer depth")

endmodule

>>> tb/group_reverse_stream_tb.sv
// Self-checking testbench for group_reverse_stream: drives value lists under several
// group sizes with random idling and stalls, and checks every output beat in order.
// Depends on grs_pkg and the group_reverse_stream RTL.

typedef struct {
	logic signed [grs_pkg::VALUE_W-1:0] value;
	logic                               group_end;
	logic                               list_close;
} reversed_beat_t;

class reversal_scoreboard;
	logic [grs_pkg::CFG_W-1:0]          size_reg;
	logic signed [grs_pkg::VALUE_W-1:0] held_q[$];
	reversed_beat_t                     due_q[$];
	int                                 mismatches;

	function new();
		size_reg   = grs_pkg::GROUP_SIZE_RESET;
		mismatches = 0;
	endfunction

	function void set_size(input logic [grs_pkg::CFG_W-1:0] new_size);
		size_reg = new_size;
	endfunction

	// Buffers one accepted input beat and queues the reversed group once it closes.
	function void note_item(input logic signed [grs_pkg::VALUE_W-1:0] value,
			input logic is_last);
		int             span;
		int             r;
		reversed_beat_t beat;
		span = (size_reg == 0) ? 1 : int'(size_reg);
		if (span > grs_pkg::MAX_GROUP_DEF)
			span = grs_pkg::MAX_GROUP_DEF;
		if (held_q.size() < grs_pkg::MAX_GROUP_DEF)
			held_q.push_back(value);
		if (held_q.size() < span && !is_last)
			return;
		for (r = held_q.size() - 1; r >= 0; r--) begin
			beat.value      = held_q[r];
			beat.group_end  = (r == 0);
			beat.list_close = (r == 0) && is_last;
			due_q.push_back(beat);
		end
		held_q.delete();
	endfunction

	function void check_result(input logic signed [grs_pkg::VALUE_W-1:0] value,
			input logic gdone, input logic ldone);
		reversed_beat_t want;
		if (due_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected output beat: value=%0d group_done=%b list_done=%b",
					value, gdone, ldone);
			return;
		end
		want = due_q.pop_front();
		if (value !== want.value || gdone !== want.group_end || ldone !== want.list_close)
		begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected value=%0d gd=%b ld=%b, got value=%0d gd=%b ld=%b",
					want.value, want.group_end, want.list_close, value, gdone, ldone);
		end
	endfunction
endclass

module group_reverse_stream_tb;

	localparam int NUM_PHASES = 14;
	localparam logic [grs_pkg::CFG_W-1:0] PHASE_SIZES [NUM_PHASES] =
		'{6'd2, 6'd1, 6'd3, 6'd5, 6'd63, 6'd8, 6'd0, 6'd16, 6'd32, 6'd7, 6'd33, 6'd4,
		  6'd31, 6'd2};
	localparam int PHASE_BUDGET = 18;
	localparam int LONG_HOLD    = 150;

	logic                               clk        = 1'b0;
	logic                               arst_n     = 1'b0;
	logic                               cfg_valid  = 1'b0;
	logic                               cfg_ready;
	logic [grs_pkg::CFG_W-1:0]          group_size = '0;
	logic                               in_valid   = 1'b0;
	logic                               in_stall;
	logic signed [grs_pkg::VALUE_W-1:0] item_value = '0;
	logic                               list_end   = 1'b0;
	logic                               out_valid;
	logic                               out_stall  = 1'b0;
	logic signed [grs_pkg::VALUE_W-1:0] out_value;
	logic                               group_done;
	logic                               list_done;

	reversal_scoreboard sb;
	bit src_idle  = 1'b0;
	bit sink_idle = 1'b0;
	int hold_cycles_req = 0;

	group_reverse_stream u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.group_size (group_size),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.item_value (item_value),
		.list_end   (list_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.group_done (group_done),
		.list_done  (list_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_value, group_done, list_done);
	end

	// Output back-pressure: random bursts, or one long hold when the stimulus asks.
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (hold_cycles_req > 0) begin
				n = hold_cycles_req;
				hold_cycles_req = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	task automatic send_item(input logic signed [grs_pkg::VALUE_W-1:0] value,
			input logic is_last);
		int gap;
		if (src_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		item_value <= value;
		list_end   <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(value, is_last);
	endtask

	// Drops valid and waits until every queued result beat has been checked.
	task automatic wait_for_results(input int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.due_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [grs_pkg::CFG_W-1:0] value);
		cfg_valid  <= 1'b1;
		group_size <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_size(value);
	endtask

	function automatic logic signed [grs_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_list(input int len, input bit closed);
		int i;
		for (i = 0; i < len; i++) begin
			send_item(pick_value(), closed && (i == len - 1));
			// Now and then the sender waits for the block to empty mid-list.
			if (src_idle && $urandom_range(0, 99) == 0)
				wait_for_results(0);
		end
	endtask

	initial begin
		int p;
		int sent;
		int span;
		int len;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset group size passes beats straight through.
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh7FFF_FFFF, 1'b1);
		send_item(32'sh0000_0000, 1'b0);
		send_item(-32'sd1, 1'b1);
		wait_for_results(8);

		// Size zero behaves as one.
		write_group_size(6'd0);
		send_item(32'sd1, 1'b0);
		send_item(-32'sd2, 1'b1);
		wait_for_results(8);

		// Exact group, group plus short tail, and a one-item list.
		write_group_size(6'd4);
		send_item(32'sd10, 1'b0);
		send_item(32'sd11, 1'b0);
		send_item(32'sd12, 1'b0);
		send_item(32'sd13, 1'b1);
		send_item(32'sd20, 1'b0);
		send_item(32'sd21, 1'b0);
		send_item(32'sd22, 1'b0);
		send_item(32'sd23, 1'b0);
		send_item(32'sd24, 1'b0);
		send_item(32'sd25, 1'b1);
		send_item(32'sh5A5A_A5A5, 1'b1);
		wait_for_results(8);

		// Shrinking the size below the fill level releases the whole buffer at once.
		write_group_size(6'd8);
		send_item(32'sd31, 1'b0);
		send_item(32'sd32, 1'b0);
		send_item(32'sd33, 1'b0);
		send_item(32'sd34, 1'b0);
		send_item(32'sd35, 1'b0);
		wait_for_results(8);
		write_group_size(6'd3);
		send_item(32'sd36, 1'b0);
		wait_for_results(8);

		for (p = 0; p < NUM_PHASES; p++) begin
			write_group_size(PHASE_SIZES[p]);
			src_idle  = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			sink_idle = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
			if (PHASE_SIZES[p] == 6'd8)
				hold_cycles_req = LONG_HOLD;
			span = (PHASE_SIZES[p] == 0) ? 1 : int'(PHASE_SIZES[p]);
			if (span > grs_pkg::MAX_GROUP_DEF)
				span = grs_pkg::MAX_GROUP_DEF;
			sent = 0;
			while (sent < PHASE_BUDGET) begin
				len = $urandom_range(1, (span <= 8) ? 3 * span + 2 : span + 4);
				send_list(len, 1'b1);
				sent += len;
			end
			// An open list left behind meets the next group size mid-group.
			if (p < NUM_PHASES - 1 && $urandom_range(0, 1) == 0)
				send_list($urandom_range(1, 5), 1'b0);
			wait_for_results(8);
		end

		wait_for_results(20);
		if (sb.mismatches == 0 && sb.due_q.size() == 0)
			$display("group_reverse_stream_tb OK");
		else
			$display("group_reverse_stream_tb NOT OK");
		$finish;
	end

	initial begin
		#1000000;
		$display("group_reverse_stream_tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/grs_pkg.sv
hw/rtl/grs_ram.sv
hw/rtl/grs_ctrl.sv
hw/rtl/grs_drain.sv
hw/rtl/group_reverse_stream.sv
tb/group_reverse_stream_tb.sv
